// ===== src/windowed_rms_peak_db_meter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_PEAK_DB_METER_TOP_MACROS_SVH
`define WINDOWED_RMS_PEAK_DB_METER_TOP_MACROS_SVH

// same-cycle implication
`define WRPDB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRPDB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wrpdb_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpdb_pkg
// Types and constants of the windowed RMS and peak level meter.
// ----------------------------------------------------------------------------
package wrpdb_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 48;
	localparam int PEAK_W     = 16;
	localparam int FILL_W     = 18;
	localparam int COUNT_W    = 32;
	localparam int WUS_W      = 24;
	localparam int TOTAL_W    = 32;
	localparam int TIME_W     = 38;
	localparam int LEVEL_W    = 12;
	localparam int TDATA_W    = 136;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// log2 unit
	localparam int LOG_IN_W       = 48;
	localparam int LOG_FRAC_BITS  = 16;
	localparam int LOG_INT_W      = 6;
	localparam int LOG_W          = LOG_INT_W + LOG_FRAC_BITS;
	localparam int LOG_NORM_STEPS = 6;
	localparam int LOG_STEP_W     = 5;
	localparam logic [LOG_STEP_W-1:0] LOG_LAST_STEP =
		LOG_STEP_W'(LOG_NORM_STEPS + LOG_FRAC_BITS - 1);
	localparam logic [LOG_INT_W-1:0] LOG_TOP_BIT = LOG_INT_W'(LOG_IN_W - 1);

	// level conversion
	localparam int T_W    = 24;
	localparam int TMAG_W = 22;
	localparam int PROD_W = 51;
	localparam int RND_W  = 12;
	localparam logic signed [T_W-1:0] T_FLOOR      = -24'sd2686976;
	localparam logic signed [T_W-1:0] RMS_OFFSET   = 24'sd1966080;
	localparam logic signed [T_W-1:0] PEAK_OFFSET2 = 24'sd1966080;
	localparam logic [TMAG_W-1:0]     TMAG_MAX     = 22'd2686976;
	localparam logic [28:0]           LEVEL_K      = 29'd505044526;
	localparam logic [PROD_W:0]       ROUND_HALF   = 52'd549755813888;
	localparam int                    LEVEL_SHIFT  = 40;
	localparam logic [RND_W-1:0]      FLOOR_MAG    = 12'd1200;
	localparam logic signed [LEVEL_W-1:0] FLOOR_TENTHS = -12'sd1200;

	// samples per window = floor(2 * window_us / 125)
	localparam logic [25:0]       SPW_RECIP = 26'd34359739;
	localparam int                SPW_SHIFT = 32;
	localparam logic [FILL_W-1:0] SPW_MAX   = 18'd262143;
	localparam logic [FILL_W-1:0] SPW_RESET = 18'd320;
	localparam logic [6:0]        DUR_MUL   = 7'd125;

	localparam logic [WUS_W-1:0]   WUS_RESET   = 24'd20000;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd16000;

	typedef enum logic [0:0] {
		REG_WINDOW_US    = 1'b0,
		REG_TOTAL_SAMPLES = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		LOG_SEL_SS = 2'd0,
		LOG_SEL_N  = 2'd1,
		LOG_SEL_PK = 2'd2
	} log_sel_t;

	typedef enum logic [0:0] {
		LVL_RMS  = 1'b0,
		LVL_PEAK = 1'b1
	} lvl_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHECK,
		ST_TIMES,
		ST_ENDT,
		ST_LOG_SS_GO,
		ST_LOG_SS_WAIT,
		ST_LOG_N_GO,
		ST_LOG_N_WAIT,
		ST_LOG_PK_GO,
		ST_LOG_PK_WAIT,
		ST_LVL_RMS_MUL,
		ST_LVL_RMS_RND,
		ST_LVL_PK_MUL,
		ST_LVL_PK_RND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     load_sample;
		logic     accumulate;
		logic     check;
		logic     times;
		logic     end_time;
		logic     log_start;
		log_sel_t log_sel;
		logic     level_mul;
		logic     level_rnd;
		lvl_sel_t level_sel;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic past_end;
		logic close;
		logic log_done;
		logic out_free;
	} sts_t;

endpackage

// ===== src/windowed_rms_peak_db_meter_top.sv =====
// A sample is taken in ST_IDLE, added in ST_ACC and checked in ST_CHECK; once the
// total is reached, ST_ACC adds nothing and returns to ST_IDLE. A window close runs
// the time arithmetic (ST_TIMES, ST_ENDT), three passes of the shared log2 unit (each
// a start, 6 normalise steps, 16 squaring steps and a done strobe), level scaling
// (ST_LVL_RMS_MUL to ST_LVL_PK_RND) and ST_EMIT, which loads the output register.
// The next sample is accepted while a record still waits on m_axis; a further record
// waits until that one has gone, and the input is held off meanwhile.
// ----------------------------------------------------------------------------
// windowed_rms_peak_db_meter_top
// Windowed RMS and peak level meter, levels in tenths of dBFS.
// ----------------------------------------------------------------------------
module windowed_rms_peak_db_meter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [wrpdb_pkg::SAMPLE_W-1:0] s_axis_tdata,  // sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// window index, start time, end time, rms level, peak level, zero pad
	output logic [wrpdb_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast,  // final_window
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wrpdb_pkg::PADDR_W-1:0] paddr,
	input  logic [wrpdb_pkg::PDATA_W-1:0] pwdata,
	output logic [wrpdb_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);
	import wrpdb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wrpdb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	wrpdb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

endmodule

// ===== src/wrpdb_log2.sv =====
// ----------------------------------------------------------------------------
// wrpdb_log2
// Iterative fixed-point log2: binary-search normalise, then one squaring a bit.
// ----------------------------------------------------------------------------
`include "windowed_rms_peak_db_meter_top_macros.svh"

module wrpdb_log2 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wrpdb_pkg::LOG_IN_W-1:0] x,
	output logic                         done,
	output logic [wrpdb_pkg::LOG_W-1:0]  result
);
	import wrpdb_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [LOG_STEP_W-1:0]    step_q;
	logic [LOG_IN_W-1:0]      norm_q;
	logic [LOG_INT_W-1:0]     lz_q;
	logic [31:0]              m_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;

	logic [LOG_IN_W-1:0]  norm_next;
	logic [LOG_INT_W-1:0] lz_next;
	logic [63:0]          sq;
	logic [32:0]          m2;

	always_comb begin
		norm_next = norm_q;
		lz_next   = lz_q;
		case (step_q)
			5'd0: begin
				if (norm_q[47:16] == '0) begin
					norm_next = {norm_q[15:0], 32'b0};
					lz_next   = lz_q + 6'd32;
				end
			end
			5'd1: begin
				if (norm_q[47:32] == '0) begin
					norm_next = {norm_q[31:0], 16'b0};
					lz_next   = lz_q + 6'd16;
				end
			end
			5'd2: begin
				if (norm_q[47:40] == '0) begin
					norm_next = {norm_q[39:0], 8'b0};
					lz_next   = lz_q + 6'd8;
				end
			end
			5'd3: begin
				if (norm_q[47:44] == '0) begin
					norm_next = {norm_q[43:0], 4'b0};
					lz_next   = lz_q + 6'd4;
				end
			end
			5'd4: begin
				if (norm_q[47:46] == '0) begin
					norm_next = {norm_q[45:0], 2'b0};
					lz_next   = lz_q + 6'd2;
				end
			end
			5'd5: begin
				if (!norm_q[47]) begin
					norm_next = {norm_q[46:0], 1'b0};
					lz_next   = lz_q + 6'd1;
				end
			end
			default: begin
				norm_next = norm_q;
				lz_next   = lz_q;
			end
		endcase
	end

	assign sq = 64'(m_q) * 64'(m_q);
	assign m2 = sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LOG_LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			norm_q <= x;
			lz_q   <= '0;
			frac_q <= '0;
		end else if (busy_q) begin
			if (step_q < LOG_STEP_W'(LOG_NORM_STEPS)) begin
				norm_q <= norm_next;
				lz_q   <= lz_next;
				if (step_q == LOG_STEP_W'(LOG_NORM_STEPS - 1))
					m_q <= norm_next[47:16];
			end else begin
				m_q    <= m2[32] ? m2[32:1] : m2[31:0];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], m2[32]};
			end
		end
	end

	assign done   = done_q;
	assign result = {LOG_TOP_BIT - lz_q, frac_q};

	`WRPDB_ASSERT_NXT(a_start_busy, start, busy_q, "log2 unit did not start")
	`WRPDB_ASSERT_IMP(a_done_idle, done_q, !busy_q, "log2 done while busy")
	`WRPDB_ASSERT_IMP(a_step_range, busy_q, step_q <= LOG_LAST_STEP, "log2 step overrun")

endmodule

// ===== src/wrpdb_datapath.sv =====
// ----------------------------------------------------------------------------
// wrpdb_datapath
// Window accumulators, config registers, time and level arithmetic, output reg.
// ----------------------------------------------------------------------------
`include "windowed_rms_peak_db_meter_top_macros.svh"

module wrpdb_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wrpdb_pkg::cmd_t                   cmd,
	output wrpdb_pkg::sts_t                   sts,
	input  logic [wrpdb_pkg::SAMPLE_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [wrpdb_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wrpdb_pkg::PADDR_W-1:0]     paddr,
	input  logic [wrpdb_pkg::PDATA_W-1:0]     pwdata,
	output logic [wrpdb_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import wrpdb_pkg::*;

	logic [WUS_W-1:0]   wus_q;
	logic [TOTAL_W-1:0] total_q;
	logic [FILL_W-1:0]  spw_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]   ss_q;
	logic [PEAK_W-1:0]  pk_q;
	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] wn_q;
	logic [COUNT_W-1:0] seen_q;
	logic               last_q;

	logic [55:0]        start_full_q;
	logic [TIME_W-1:0]  dur_q;
	logic [TIME_W-1:0]  endt_q;
	logic [LOG_W-1:0]   lss_q;
	logic [LOG_W-1:0]   ln_q;
	logic [LOG_W-1:0]   lpk_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEVEL_W-1:0] rms_q;
	logic [LEVEL_W-1:0] pkdb_q;

	logic               out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic               out_last_q;

	logic [PEAK_W-1:0]   mag;
	logic [31:0]         sq;
	logic [50:0]         spw_prod;
	logic [18:0]         spw_quot;
	logic [56:0]         end_full;
	logic [38:0]         dur_full;
	logic [LOG_IN_W-1:0] log_x;
	logic                log_done;
	logic [LOG_W-1:0]    log_res;
	logic signed [T_W-1:0] t;
	logic [TMAG_W-1:0]   tmag;
	logic [PROD_W:0]     rnd_sum;
	logic [RND_W-1:0]    rnd;
	logic [LEVEL_W-1:0]  level;
	logic [LEVEL_W-1:0]  rms_out;
	logic [LEVEL_W-1:0]  pk_out;
	logic                cfg_wr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_TOTAL_SAMPLES) ? total_q
		: PDATA_W'(wus_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wus_q   <= WUS_RESET;
			total_q <= TOTAL_RESET;
			spw_q   <= SPW_RESET;
		end else begin
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[2]))
					REG_WINDOW_US:     wus_q   <= pwdata[WUS_W-1:0];
					REG_TOTAL_SAMPLES: total_q <= pwdata;
					default:           wus_q   <= wus_q;
				endcase
			end
			if (spw_quot == '0)
				spw_q <= FILL_W'(1);
			else if (spw_quot > 19'(SPW_MAX))
				spw_q <= SPW_MAX;
			else
				spw_q <= spw_quot[FILL_W-1:0];
		end
	end

	assign spw_prod = 51'({wus_q, 1'b0}) * 51'(SPW_RECIP);
	assign spw_quot = spw_prod[50:SPW_SHIFT];

	// accumulation
	assign mag = sample_q[SAMPLE_W-1] ? PEAK_W'(-sample_q) : PEAK_W'(sample_q);
	assign sq  = 32'(mag) * 32'(mag);

	assign sts.past_end = seen_q >= total_q;
	assign sts.close    = (seen_q >= total_q) || (fill_q >= spw_q);
	assign sts.log_done = log_done;
	assign sts.out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk) begin
		if (cmd.load_sample)
			sample_q <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q   <= '0;
			pk_q   <= '0;
			fill_q <= '0;
			wn_q   <= '0;
			seen_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.accumulate && !sts.past_end) begin
				ss_q   <= ss_q + SUM_W'(sq);
				if (mag > pk_q)
					pk_q <= mag;
				fill_q <= fill_q + FILL_W'(1);
				seen_q <= seen_q + COUNT_W'(1);
			end
			if (cmd.check)
				last_q <= seen_q >= total_q;
			if (cmd.emit) begin
				ss_q   <= '0;
				pk_q   <= '0;
				fill_q <= '0;
				wn_q   <= wn_q + COUNT_W'(1);
			end
		end
	end

	// record times
	assign dur_full = 39'(total_q) * 39'(DUR_MUL);
	assign end_full = 57'(start_full_q) + 57'(wus_q);

	always_ff @(posedge clk) begin
		if (cmd.times) begin
			start_full_q <= 56'(wn_q) * 56'(wus_q);
			dur_q        <= dur_full[38:1];
		end
		if (cmd.end_time)
			endt_q <= (57'(dur_q) < end_full) ? dur_q : end_full[TIME_W-1:0];
	end

	// log2 operand select and result capture
	always_comb begin
		case (cmd.log_sel)
			LOG_SEL_SS: log_x = ss_q;
			LOG_SEL_N:  log_x = LOG_IN_W'(fill_q);
			LOG_SEL_PK: log_x = LOG_IN_W'(pk_q);
			default:    log_x = ss_q;
		endcase
	end

	wrpdb_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	always_ff @(posedge clk) begin
		if (log_done) begin
			case (cmd.log_sel)
				LOG_SEL_SS: lss_q <= log_res;
				LOG_SEL_N:  ln_q  <= log_res;
				LOG_SEL_PK: lpk_q <= log_res;
				default:    lss_q <= log_res;
			endcase
		end
	end

	// level: clamp, scale by 100*log10(2), round half away from zero
	always_comb begin
		if (cmd.level_sel == LVL_PEAK)
			t = T_W'({1'b0, lpk_q, 1'b0}) - PEAK_OFFSET2;
		else
			t = T_W'(lss_q) - T_W'(ln_q) - RMS_OFFSET;
		if (!t[T_W-1])
			tmag = '0;
		else if (t < T_FLOOR)
			tmag = TMAG_MAX;
		else
			tmag = TMAG_W'(-t);
	end

	assign rnd_sum = 52'(prod_q) + ROUND_HALF;
	assign rnd     = rnd_sum[PROD_W:LEVEL_SHIFT];
	assign level   = (rnd > FLOOR_MAG) ? FLOOR_TENTHS : LEVEL_W'(-rnd);

	always_ff @(posedge clk) begin
		if (cmd.level_mul)
			prod_q <= PROD_W'(tmag) * PROD_W'(LEVEL_K);
		if (cmd.level_rnd) begin
			if (cmd.level_sel == LVL_PEAK)
				pkdb_q <= level;
			else
				rms_q <= level;
		end
	end

	assign rms_out = (ss_q == '0) ? FLOOR_TENTHS : rms_q;
	assign pk_out  = (pk_q == '0) ? FLOOR_TENTHS : pkdb_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {4'b0, pk_out, rms_out, endt_q, start_full_q[TIME_W-1:0], wn_q};
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`WRPDB_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "record issued over a held one")
	`WRPDB_ASSERT_NXT(a_seen_step, cmd.accumulate && !sts.past_end,
		seen_q == $past(seen_q) + COUNT_W'(1), "sample count did not advance")
	`WRPDB_ASSERT_NXT(a_emit_clear, cmd.emit, out_valid_q && fill_q == '0,
		"window not closed on emit")

endmodule

// ===== src/wrpdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrpdb_ctrl
// Sequencer: takes a sample, accumulates it and, on a window close, runs the
// time, log2 and level steps before handing the record to the output register.
// ----------------------------------------------------------------------------
module wrpdb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  wrpdb_pkg::sts_t sts,
	output wrpdb_pkg::cmd_t cmd
);
	import wrpdb_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:        if (s_axis_tvalid) state_next = ST_ACC;
			ST_ACC:         state_next = sts.past_end ? ST_IDLE : ST_CHECK;
			ST_CHECK:       state_next = sts.close ? ST_TIMES : ST_IDLE;
			ST_TIMES:       state_next = ST_ENDT;
			ST_ENDT:        state_next = ST_LOG_SS_GO;
			ST_LOG_SS_GO:   state_next = ST_LOG_SS_WAIT;
			ST_LOG_SS_WAIT: if (sts.log_done) state_next = ST_LOG_N_GO;
			ST_LOG_N_GO:    state_next = ST_LOG_N_WAIT;
			ST_LOG_N_WAIT:  if (sts.log_done) state_next = ST_LOG_PK_GO;
			ST_LOG_PK_GO:   state_next = ST_LOG_PK_WAIT;
			ST_LOG_PK_WAIT: if (sts.log_done) state_next = ST_LVL_RMS_MUL;
			ST_LVL_RMS_MUL: state_next = ST_LVL_RMS_RND;
			ST_LVL_RMS_RND: state_next = ST_LVL_PK_MUL;
			ST_LVL_PK_MUL:  state_next = ST_LVL_PK_RND;
			ST_LVL_PK_RND:  state_next = ST_EMIT;
			ST_EMIT:        if (sts.out_free) state_next = ST_IDLE;
			default:        state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.log_sel   = LOG_SEL_SS;
		cmd.level_sel = LVL_RMS;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready   = 1'b1;
				cmd.load_sample = s_axis_tvalid;
			end
			ST_ACC:         cmd.accumulate = 1'b1;
			ST_CHECK:       cmd.check = 1'b1;
			ST_TIMES:       cmd.times = 1'b1;
			ST_ENDT:        cmd.end_time = 1'b1;
			ST_LOG_SS_GO:   cmd.log_start = 1'b1;
			ST_LOG_SS_WAIT: cmd.log_sel = LOG_SEL_SS;
			ST_LOG_N_GO: begin
				cmd.log_start = 1'b1;
				cmd.log_sel   = LOG_SEL_N;
			end
			ST_LOG_N_WAIT:  cmd.log_sel = LOG_SEL_N;
			ST_LOG_PK_GO: begin
				cmd.log_start = 1'b1;
				cmd.log_sel   = LOG_SEL_PK;
			end
			ST_LOG_PK_WAIT: cmd.log_sel = LOG_SEL_PK;
			ST_LVL_RMS_MUL: cmd.level_mul = 1'b1;
			ST_LVL_RMS_RND: cmd.level_rnd = 1'b1;
			ST_LVL_PK_MUL: begin
				cmd.level_mul = 1'b1;
				cmd.level_sel = LVL_PEAK;
			end
			ST_LVL_PK_RND: begin
				cmd.level_rnd = 1'b1;
				cmd.level_sel = LVL_PEAK;
			end
			ST_EMIT:        cmd.emit = sts.out_free;
			default:        cmd = '0;
		endcase
	end

endmodule
